[design/mtt_pkg.sv]
// Shared types, constants and arithmetic helpers for the transposed matrix multiply.
package mtt_pkg;

  localparam int MAX_ROWS_DEF  = 16;
  localparam int MAX_INNER_DEF = 64;
  localparam int COL_SPAN      = 64;

  localparam int VAL_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W = 38;
  localparam int OUT_W = 32;
  localparam int FRAC_SHIFT = 12;

  localparam logic [4:0] ROWS_A_RST    = 5'd16;
  localparam logic [6:0] INNER_LEN_RST = 7'd64;

  typedef enum logic [0:0] {
    REG_ROWS_A    = 1'b0,
    REG_INNER_LEN = 1'b1
  } cfg_reg_t;

  // Per-cycle controls broadcast along the cell row.
  typedef struct packed {
    logic mul;
    logic acc;
    logic clear;
    logic load;
    logic shift;
  } mtt_ctl_t;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 38'sh00_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_MIN = 38'sh3F_8000_0000;

  // Q.24 accumulator to Q.12: floor shift, then clamp to 32 bits.
  function automatic logic signed [OUT_W-1:0] scale_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] s;
    s = acc >>> FRAC_SHIFT;
    if (s > SAT_MAX) begin
      scale_sat = SAT_MAX[OUT_W-1:0];
    end else if (s < SAT_MIN) begin
      scale_sat = SAT_MIN[OUT_W-1:0];
    end else begin
      scale_sat = s[OUT_W-1:0];
    end
  endfunction

endpackage

[design/matrix_multiply_transposed.sv]
// Top level: C = A * B^T over a row of accumulate cells, results shifted out of cell 0.
// A write: accepted while idle, busy stays low. B element that does not end a row: busy through
// multiply and accumulate (the row-store read happens at acceptance), then back to idle.
// B element at the last inner position: multiply, accumulate, load, then one result per cycle
// for each active row of A (rows_a clamped to 1..MAX_ROWS); busy through the last result.
// Results leave through the cell shift chain, one per cycle, and cannot be stalled.
// Synchronous reset clears the accumulators and sets rows_a = 16, inner_len = 64; A is unset.
module matrix_multiply_transposed #(
  parameter int MAX_ROWS  = mtt_pkg::MAX_ROWS_DEF,
  parameter int MAX_INNER = mtt_pkg::MAX_INNER_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [0:0]                         cfg_addr,
  input  logic [6:0]                         cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic [7:0]                         in_row_index,
  input  logic [5:0]                         in_col_index,
  input  logic signed [mtt_pkg::VAL_W-1:0]   in_value,
  output logic                               out_valid,
  output logic [3:0]                         out_row,
  output logic [7:0]                         out_col,
  output logic signed [mtt_pkg::OUT_W-1:0]   out_value,
  output logic                               out_last
);

  localparam int ACOLS = (MAX_INNER < mtt_pkg::COL_SPAN) ? MAX_INNER : mtt_pkg::COL_SPAN;
  localparam int AW    = (ACOLS > 1) ? $clog2(ACOLS) : 1;
  localparam int NR_W  = $clog2(MAX_ROWS + 1);
  localparam int RW    = (NR_W > 5) ? NR_W : 5;
  localparam int CNT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_LOAD,
    ST_SHIFT
  } state_t;

  state_t                           state_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [4:0]                       rows_a_r;
  logic [6:0]                       inner_len_r;
  logic signed [mtt_pkg::VAL_W-1:0] b_r;
  logic                             clear_r;
  logic                             fin_r;
  logic [7:0]                       col_r;

  logic [RW-1:0] rows_ext;
  logic [RW-1:0] rows_eff;
  logic [6:0]    inner_eff;
  logic          accept;
  logic          a_wr;
  logic          b_go;
  logic          at_last;
  mtt_pkg::mtt_ctl_t ctl;
  logic signed [mtt_pkg::OUT_W-1:0] res [MAX_ROWS];

  // Out-of-range register values are clamped.
  assign rows_ext  = RW'(rows_a_r);
  assign rows_eff  = (rows_ext == '0) ? RW'(1) :
                     (rows_ext > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : rows_ext;
  assign inner_eff = (inner_len_r == '0) ? 7'd1 :
                     (inner_len_r > 7'(ACOLS)) ? 7'(ACOLS) : inner_len_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign a_wr   = accept && !in_func && (in_row_index < 8'(MAX_ROWS))
                  && ({1'b0, in_col_index} < 7'(ACOLS));
  assign b_go   = accept && in_func && ({1'b0, in_col_index} < inner_eff);
  assign at_last = (RW'(cnt_r) == (rows_eff - RW'(1)));

  assign ctl.mul   = (state_r == ST_MUL);
  assign ctl.acc   = (state_r == ST_ACC);
  assign ctl.clear = clear_r;
  assign ctl.load  = (state_r == ST_LOAD);
  assign ctl.shift = (state_r == ST_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mtt_pkg::ROWS_A_RST;
      inner_len_r <= mtt_pkg::INNER_LEN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        mtt_pkg::REG_ROWS_A:    rows_a_r    <= cfg_wdata[4:0];
        mtt_pkg::REG_INNER_LEN: inner_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (b_go) begin
            state_r <= ST_MUL;
            b_r     <= in_value;
            col_r   <= in_row_index;
            clear_r <= (in_col_index == '0);
            fin_r   <= ({1'b0, in_col_index} == (inner_eff - 7'd1));
          end
        end
        ST_MUL: begin
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          state_r <= fin_r ? ST_LOAD : ST_IDLE;
        end
        ST_LOAD: begin
          state_r <= ST_SHIFT;
          cnt_r   <= '0;
        end
        ST_SHIFT: begin
          if (at_last) begin
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    logic signed [mtt_pkg::OUT_W-1:0] nb;
    if (k == MAX_ROWS - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = res[k+1];
    end

    mtt_cell #(
      .ACOLS (ACOLS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .active   (RW'(k) < rows_eff),
      .wr_en    (a_wr && (in_row_index == 8'(k))),
      .wr_addr  (in_col_index[AW-1:0]),
      .wr_data  (in_value),
      .rd_en    (b_go),
      .rd_addr  (in_col_index[AW-1:0]),
      .b_value  (b_r),
      .shift_in (nb),
      .res_out  (res[k])
    );
  end

  assign out_valid = (state_r == ST_SHIFT);
  assign out_row   = 4'(cnt_r);
  assign out_col   = col_r;
  assign out_value = res[0];
  assign out_last  = out_valid && at_last;

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while not busy");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid && !busy)
    else $error("results continue after the final one of a column");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_col == $past(out_col)))
    else $error("result burst broken");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid)
    else $error("result directly after a transaction");

endmodule

[design/mtt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mtt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

[design/mtt_cell.sv]
// One A-row cell: row store, multiply, accumulate, and a result shift stage.
module mtt_cell #(
  parameter int ACOLS = mtt_pkg::COL_SPAN
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  mtt_pkg::mtt_ctl_t                           ctl,
  input  logic                                        active,
  input  logic                                        wr_en,
  input  logic [((ACOLS > 1) ? $clog2(ACOLS) : 1)-1:0] wr_addr,
  input  logic signed [mtt_pkg::VAL_W-1:0]            wr_data,
  input  logic                                        rd_en,
  input  logic [((ACOLS > 1) ? $clog2(ACOLS) : 1)-1:0] rd_addr,
  input  logic signed [mtt_pkg::VAL_W-1:0]            b_value,
  input  logic signed [mtt_pkg::OUT_W-1:0]            shift_in,
  output logic signed [mtt_pkg::OUT_W-1:0]            res_out
);

  logic [mtt_pkg::VAL_W-1:0]         a_rd;
  logic signed [mtt_pkg::PROD_W-1:0] prod_r;
  logic signed [mtt_pkg::ACC_W-1:0]  acc_r;
  logic signed [mtt_pkg::ACC_W-1:0]  acc_base;
  logic signed [mtt_pkg::ACC_W-1:0]  prod_ext;
  logic signed [mtt_pkg::OUT_W-1:0]  res_r;

  mtt_ram #(
    .WIDTH (mtt_pkg::VAL_W),
    .DEPTH (ACOLS)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (a_rd)
  );

  assign acc_base = ctl.clear ? '0 : acc_r;
  assign prod_ext = {{(mtt_pkg::ACC_W - mtt_pkg::PROD_W){prod_r[mtt_pkg::PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= $signed(a_rd) * b_value;
    end
  end

  // Accumulator wraps at 38 bits; inactive rows are only cleared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.acc) begin
      acc_r <= active ? (acc_base + prod_ext) : acc_base;
    end else if (ctl.load && active) begin
      acc_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_r <= mtt_pkg::scale_sat(acc_r);
    end else if (ctl.shift) begin
      res_r <= shift_in;
    end
  end

  assign res_out = res_r;

endmodule

[test/tb.sv]
// Self-checking testbench for matrix_multiply_transposed: A store writes, streamed B rows, C checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS  = mtt_pkg::MAX_ROWS_DEF;
  localparam int NINNER = mtt_pkg::MAX_INNER_DEF;
  localparam int ACC_W  = mtt_pkg::ACC_W;

  typedef enum logic {
    FN_A_WRITE = 1'b0,
    FN_B_ELEM  = 1'b1
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  row;
    logic [5:0]  col;
    logic [15:0] value;
  } mm_op_t;

  typedef struct packed {
    logic [3:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
    logic        last;
  } c_entry_t;

  localparam int STALL_LIMIT = 1000;
  localparam int ITEM_TARGET = 170;
  // block of A written up front; random traffic reads only inside it
  localparam int FILL_ROWS = 4;
  localparam int FILL_COLS = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [6:0]  cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = 1'b0;
  logic [7:0]  in_row_index = '0;
  logic [5:0]  in_col_index = '0;
  logic signed [mtt_pkg::VAL_W-1:0] in_value = '0;
  logic        out_valid;
  logic [3:0]  out_row;
  logic [7:0]  out_col;
  logic signed [mtt_pkg::OUT_W-1:0] out_value;
  logic        out_last;

  matrix_multiply_transposed DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .out_last     (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mm_op_t   op_queue[$];
  c_entry_t c_expected[$];
  mm_op_t   cur_op;
  c_entry_t mon_entry;
  int       n_queued = 0;
  int       n_accepted = 0;
  int       errors = 0;
  int       stall_cycles = 0;
  bit       no_idle = 1'b0;

  // predictor state
  logic [15:0]      a_mem [NROWS*NINNER];
  logic [ACC_W-1:0] acc_q [NROWS];
  logic [4:0]       m_rows_raw;
  logic [6:0]       m_inner_raw;

  // stimulus-side view of the effective inner length
  int g_inner = NINNER;

  function automatic int eff_rows(logic [4:0] raw);
    if (raw == 0) return 1;
    if (raw > NROWS) return NROWS;
    return int'(raw);
  endfunction

  function automatic int eff_inner(logic [6:0] raw);
    int lim;
    lim = (NINNER < mtt_pkg::COL_SPAN) ? NINNER : mtt_pkg::COL_SPAN;
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return int'(raw);
  endfunction

  task automatic predict_c(input mm_op_t op);
    int nr;
    int ni;
    logic signed [31:0] prod;
    longint sum;
    longint q;
    c_entry_t e;
    if (op.func == FN_A_WRITE) begin
      if (op.row < NROWS && op.col < NINNER)
        a_mem[int'(op.row) * NINNER + int'(op.col)] = op.value;
      return;
    end
    nr = eff_rows(m_rows_raw);
    ni = eff_inner(m_inner_raw);
    if (op.col >= ni) return;
    if (op.col == 0) begin
      for (int r = 0; r < NROWS; r++) acc_q[r] = '0;
    end
    for (int r = 0; r < nr; r++) begin
      prod = $signed(a_mem[r * NINNER + int'(op.col)]) * $signed(op.value);
      acc_q[r] = acc_q[r] + {{(ACC_W-32){prod[31]}}, prod};
    end
    if (op.col != ni - 1) return;
    for (int r = 0; r < nr; r++) begin
      sum = longint'($signed(acc_q[r]));
      q = sum >>> mtt_pkg::FRAC_SHIFT;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      e.row = r[3:0];
      e.col = op.row;
      e.value = q[31:0];
      e.last = (r == nr - 1);
      c_expected.push_back(e);
      acc_q[r] = '0;
    end
  endtask

  // driver: accepted transactions feed the predictor, then the next op goes on the bus
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      m_rows_raw = mtt_pkg::ROWS_A_RST;
      m_inner_raw = mtt_pkg::INNER_LEN_RST;
      for (int r = 0; r < NROWS; r++) acc_q[r] = '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          mtt_pkg::REG_ROWS_A:    m_rows_raw = cfg_wdata[4:0];
          mtt_pkg::REG_INNER_LEN: m_inner_raw = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_c(cur_op);
        n_accepted++;
      end
      if (!start || !busy) begin
        if (op_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
          cur_op = op_queue.pop_front();
          in_func <= cur_op.func;
          in_row_index <= cur_op.row;
          in_col_index <= cur_op.col;
          in_value <= cur_op.value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (c_expected.size() == 0) begin
        $error("unexpected result: row %0d col %0d value %0d", out_row, out_col, out_value);
        errors++;
      end else begin
        mon_entry = c_expected.pop_front();
        if (out_row !== mon_entry.row) begin
          $error("out_row: expected %0d, got %0d", mon_entry.row, out_row);
          errors++;
        end
        if (out_col !== mon_entry.col) begin
          $error("out_col: expected %0d, got %0d", mon_entry.col, out_col);
          errors++;
        end
        if (out_value !== $signed(mon_entry.value)) begin
          $error("out_value: expected %0d, got %0d", $signed(mon_entry.value), out_value);
          errors++;
        end
        if (out_last !== mon_entry.last) begin
          $error("out_last: expected %0d, got %0d", mon_entry.last, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_a(input int row, input int col, input logic [15:0] value);
    mm_op_t op;
    op.func = FN_A_WRITE;
    op.row = row[7:0];
    op.col = col[5:0];
    op.value = value;
    op_queue.push_back(op);
    n_queued++;
  endtask

  task automatic push_b(input int row, input int col, input logic [15:0] value);
    mm_op_t op;
    op.func = FN_B_ELEM;
    op.row = row[7:0];
    op.col = col[5:0];
    op.value = value;
    op_queue.push_back(op);
    n_queued++;
  endtask

  // wait until every transaction is in and every result is out, then let the block settle
  task automatic drain(input int settle);
    do @(posedge clk);
    while (n_accepted != n_queued || c_expected.size() != 0 || busy);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input mtt_pkg::cfg_reg_t idx, input logic [6:0] data);
    drain(8);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == mtt_pkg::REG_INNER_LEN) g_inner = eff_inner(data);
  endtask

  task automatic push_b_row(input int row);
    for (int c = 0; c < g_inner; c++) begin
      if ($urandom_range(0, 5) == 0)
        push_a($urandom_range(0, 31), $urandom_range(0, 63), pick_elem());
      push_b(row, c, pick_elem());
    end
  endtask

  // sizes stay inside the prefilled block of A
  task automatic random_phase();
    int k;
    case ($urandom_range(0, 9))
      0: write_reg(mtt_pkg::REG_ROWS_A, 7'd0);
      default: begin
        write_reg(mtt_pkg::REG_ROWS_A,
                  {2'($urandom), 5'($urandom_range(1, FILL_ROWS))});
      end
    endcase
    case ($urandom_range(0, 9))
      0: write_reg(mtt_pkg::REG_INNER_LEN, 7'd0);
      default: write_reg(mtt_pkg::REG_INNER_LEN, 7'($urandom_range(1, FILL_COLS)));
    endcase
    repeat ($urandom_range(2, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: push_b_row($urandom_range(0, 255));
        6: begin
          repeat ($urandom_range(1, 4))
            push_a($urandom_range(0, 31), $urandom_range(0, 63), pick_elem());
        end
        7: begin
          // abandoned row: the next position zero throws it away
          k = $urandom_range(1, g_inner);
          for (int c = 0; c < k - 1; c++) push_b($urandom_range(0, 255), c, pick_elem());
          push_b_row($urandom_range(0, 255));
        end
        8: begin
          repeat ($urandom_range(1, 5))
            push_b($urandom_range(0, 255), $urandom_range(0, g_inner - 1), pick_elem());
        end
        default: begin
          push_b($urandom_range(0, 255), $urandom_range(0, 63), pick_elem());
          push_a($urandom_range(16, 255), $urandom_range(0, 63), pick_elem());
        end
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A entries that later reads touch: a small block, position zero of every row,
    // and the last position of row 0
    for (int r = 0; r < FILL_ROWS; r++) begin
      for (int c = 0; c < FILL_COLS; c++) begin
        case ((r + c) % 4)
          0: push_a(r, c, 16'h7FFF);
          1: push_a(r, c, 16'h8000);
          2: push_a(r, c, 16'h0000);
          default: push_a(r, c, 16'($urandom));
        endcase
      end
    end
    for (int r = FILL_ROWS; r < NROWS; r++) push_a(r, 0, pick_elem());
    push_a(0, NINNER - 1, 16'h7FFF);

    write_reg(mtt_pkg::REG_ROWS_A, 7'd3);
    write_reg(mtt_pkg::REG_INNER_LEN, 7'd4);
    push_a(200, 5, 16'h1234);          // row out of range, dropped
    push_b(7, 10, 16'h7FFF);           // past the inner length, no results
    push_b(7, 0, 16'h8000);
    push_b(7, 1, 16'h7FFF);            // unfinished, discarded by the next position zero
    push_b(8, 0, 16'h7FFF);
    push_b(8, 1, 16'h8000);
    push_b(8, 2, 16'h0001);
    push_b(8, 3, 16'hFFFF);
    push_b(9, 2, 16'h4000);            // out of order and repeated
    push_b(9, 1, 16'hC000);
    push_b(9, 1, 16'hC000);
    push_b(9, 3, 16'h8000);

    write_reg(mtt_pkg::REG_ROWS_A, 7'd0);
    write_reg(mtt_pkg::REG_INNER_LEN, 7'd0);
    push_b(0, 0, 16'h8000);            // position zero is also the last one
    push_b(3, 5, 16'h1111);

    write_reg(mtt_pkg::REG_ROWS_A, 7'h7F);
    write_reg(mtt_pkg::REG_INNER_LEN, 7'd1);
    push_b(255, 0, 16'h7FFF);          // all rows, position zero only

    write_reg(mtt_pkg::REG_ROWS_A, 7'd1);
    write_reg(mtt_pkg::REG_INNER_LEN, 7'h7F);
    push_b(128, 0, 16'h8000);          // clamped length: only the ends of the row
    push_b(128, NINNER - 1, 16'h8000);

    // stretch where the sender never idles
    write_reg(mtt_pkg::REG_ROWS_A, 7'(FILL_ROWS));
    write_reg(mtt_pkg::REG_INNER_LEN, 7'(FILL_COLS));
    no_idle = 1'b1;
    repeat (3) push_b_row($urandom_range(0, 255));
    drain(1);
    no_idle = 1'b0;

    while (n_queued < ITEM_TARGET) random_phase();

    drain(30);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
